// ===== sv/double_ended_queue_macros.svh =====
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
package dq_pkg;

   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_QUERY      = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int WORD_W = 32;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;

   typedef struct packed {
      logic load;
      logic exec;
      logic rd;
   } dq_cmd_type;

endpackage

// ===== sv/dq_ram.sv =====
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dq_ctrl.sv =====
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_READ;
         S_READ: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign cmd.load   = req_tready && req_tvalid;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.rd     = (state_ff == S_READ);

endmodule

// ===== sv/dq_dpath.sv =====
module dq_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::dq_cmd_type            cmd,
   input  logic [dq_pkg::MODE_W-1:0]     mode,
   input  logic [dq_pkg::WORD_W-1:0]     value,
   output logic [dq_pkg::WORD_W-1:0]     front_value,
   output logic [dq_pkg::WORD_W-1:0]     back_value,
   output logic [$clog2(DEPTH+1)-1:0]    occupancy,
   output logic                          is_empty,
   output logic [dq_pkg::STAT_W-1:0]     status
);
   import dq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
      return (s == '0) ? LAST_SLOT : s - PTR_W'(1);
   endfunction

   logic [MODE_W-1:0] mode_ff;
   logic [WORD_W-1:0] value_ff;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [PTR_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [WORD_W-1:0] rd_front;
   logic [WORD_W-1:0] rd_back;
   logic              full;
   logic              empty;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      case (mode_ff)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               front_in = slot_prev(front_ff);
               wr_addr  = slot_prev(front_ff);
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               back_in  = slot_next(back_ff);
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               front_in = slot_next(front_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               back_in  = slot_prev(back_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode;
         value_ff <= value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // two copies of the store, one per read port
   dq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram_front (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.rd),
      .rd_addr (front_ff),
      .rd_data (rd_front)
   );

   dq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram_back (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.rd),
      .rd_addr (slot_prev(back_ff)),
      .rd_data (rd_back)
   );

   assign front_value = empty ? '0 : rd_front;
   assign back_value  = empty ? '0 : rd_back;
   assign occupancy   = count_ff;
   assign is_empty    = empty;
   assign status      = status_ff;

endmodule

// ===== sv/double_ended_queue.sv =====
// sequence: an input transfer is registered, then the deque is updated, the store
//   is read and the result is made valid; no new transfer is taken until the result
//   is taken, per the accept, update, store read and result steps of the controller
// reset: synchronous, clears front and back slots, count and controller state;
//   store contents stay undefined until pushed, no clearing pass
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [dq_pkg::WORD_W-1:0]               req_tdata,  // value
   input  logic [dq_pkg::MODE_W-1:0]               req_tuser,  // mode
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // front_value, back_value, occupancy, is_empty, zero pad
   output logic [((65 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [dq_pkg::STAT_W-1:0]               rsp_tuser   // status
);
   import dq_pkg::*;

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TDATA_W = ((65 + CNT_W + 7) / 8) * 8;

   dq_cmd_type        cmd;
   logic [WORD_W-1:0] front_value;
   logic [WORD_W-1:0] back_value;
   logic [CNT_W-1:0]  occupancy;
   logic              is_empty;
   logic [STAT_W-1:0] status;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mode        (req_tuser),
      .value       (req_tdata),
      .front_value (front_value),
      .back_value  (back_value),
      .occupancy   (occupancy),
      .is_empty    (is_empty),
      .status      (status)
   );

   assign rsp_tdata = TDATA_W'({is_empty, occupancy, back_value, front_value});
   assign rsp_tuser = status;

   `DQ_ASSERT_SAME(a_full_count, clock, reset, rsp_tvalid && status == STATUS_FULL,
      occupancy == CNT_W'(DEPTH), "push dropped while not full")
   `DQ_ASSERT_SAME(a_empty_zero, clock, reset, rsp_tvalid && is_empty,
      front_value == '0 && back_value == '0 && occupancy == '0, "empty result not zero")
   `DQ_ASSERT_SAME(a_pop_empty, clock, reset, rsp_tvalid && status == STATUS_EMPTY,
      is_empty, "pop ignored on non-empty deque")
   `DQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready,
      !req_tready && !rsp_tvalid, "new transfer taken while busy")

endmodule

// ===== dv/double_ended_queue_checker.sv =====
`timescale 1ns / 1ps

module double_ended_queue_checker #(
   parameter int DEPTH = 64,
   parameter int RSP_W = 72
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [dq_pkg::WORD_W-1:0] req_tdata,   // value
   input  logic [dq_pkg::MODE_W-1:0] req_tuser,   // mode
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_W-1:0]          rsp_tdata,   // front_value, back_value, occupancy, is_empty
   input  logic [dq_pkg::STAT_W-1:0] rsp_tuser,   // status
   output int                        mismatches,
   output int                        outstanding
);
   import dq_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] front_value;
      logic [WORD_W-1:0] back_value;
      logic [OCC_W-1:0]  occupancy;
      logic              is_empty;
      logic [STAT_W-1:0] status;
   } deque_view_type;

   logic [WORD_W-1:0] held_words[$];
   deque_view_type    expected_views[$];

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   task automatic note_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      $display("mismatch in %s at %0t: expected %h, got %h", field, $realtime, want, got);
      mismatches++;
   endtask

   // applies one operation to the model deque and returns the view after it
   function automatic deque_view_type apply_operation(logic [MODE_W-1:0] mode,
                                                      logic [WORD_W-1:0] value);
      deque_view_type view;
      view.status = STATUS_DONE;
      case (mode)
         MODE_PUSH_FRONT: begin
            if (held_words.size() >= DEPTH) view.status = STATUS_FULL;
            else held_words.push_front(value);
         end
         MODE_PUSH_BACK: begin
            if (held_words.size() >= DEPTH) view.status = STATUS_FULL;
            else held_words.push_back(value);
         end
         MODE_POP_FRONT: begin
            if (held_words.size() == 0) view.status = STATUS_EMPTY;
            else void'(held_words.pop_front());
         end
         MODE_POP_BACK: begin
            if (held_words.size() == 0) view.status = STATUS_EMPTY;
            else void'(held_words.pop_back());
         end
         default: begin
         end
      endcase
      view.occupancy = OCC_W'(held_words.size());
      view.is_empty = (held_words.size() == 0);
      view.front_value = view.is_empty ? '0 : held_words[0];
      view.back_value = view.is_empty ? '0 : held_words[$];
      return view;
   endfunction

   always @(posedge clock) begin
      deque_view_type got;
      deque_view_type want;
      if (reset) begin
         held_words.delete();
         expected_views.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.front_value = rsp_tdata[WORD_W-1:0];
            got.back_value = rsp_tdata[2*WORD_W-1:WORD_W];
            got.occupancy = rsp_tdata[2*WORD_W+OCC_W-1:2*WORD_W];
            got.is_empty = rsp_tdata[2*WORD_W+OCC_W];
            got.status = rsp_tuser;
            if (expected_views.size() == 0) begin
               note_mismatch("unexpected result transfer", '0, got.front_value);
            end else begin
               want = expected_views.pop_front();
               if (got.front_value !== want.front_value)
                  note_mismatch("front_value", want.front_value, got.front_value);
               if (got.back_value !== want.back_value)
                  note_mismatch("back_value", want.back_value, got.back_value);
               if (got.occupancy !== want.occupancy)
                  note_mismatch("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
               if (got.is_empty !== want.is_empty)
                  note_mismatch("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
               if (got.status !== want.status)
                  note_mismatch("status", WORD_W'(want.status), WORD_W'(got.status));
            end
         end
         if (req_tvalid && req_tready)
            expected_views.push_back(apply_operation(req_tuser, req_tdata));
         outstanding <= expected_views.size();
      end
   end

endmodule

// ===== dv/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_tb;
   import dq_pkg::*;

   localparam int DEPTH = 64;
   localparam int RSP_W = ((65 + $clog2(DEPTH + 1) + 7) / 8) * 8;
   localparam int RANDOM_OPS = 1350;

   localparam int BIAS_FILL  = 0;
   localparam int BIAS_DRAIN = 1;
   localparam int BIAS_MIX   = 2;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata;   // value
   logic [MODE_W-1:0] req_tuser;   // mode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // front_value, back_value, occupancy, is_empty
   logic [STAT_W-1:0] rsp_tuser;   // status
   int                mismatches;
   int                outstanding;
   bit                steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   double_ended_queue_checker #(
      .DEPTH(DEPTH),
      .RSP_W(RSP_W)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   task automatic send_operation(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= mode;
      req_tdata <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(int bias);
      int roll;
      int push_pct;
      int pop_pct;
      roll = $urandom_range(0, 99);
      push_pct = (bias == BIAS_FILL) ? 75 : (bias == BIAS_DRAIN) ? 15 : 42;
      pop_pct = (bias == BIAS_FILL) ? 15 : (bias == BIAS_DRAIN) ? 75 : 42;
      if (roll < push_pct)
         return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      if (roll < push_pct + pop_pct)
         return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      // query and the unused codes above it
      return MODE_QUERY + MODE_W'($urandom_range(0, 3));
   endfunction

   // result side: per-transfer random stall
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int sent;
      int seg_len;
      int bias;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_QUERY;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty corner, extremes at both ends, unused codes, drain to empty
      send_operation(MODE_QUERY, $urandom);
      send_operation(MODE_POP_FRONT, $urandom);
      send_operation(MODE_POP_BACK, $urandom);
      send_operation(MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_operation(MODE_PUSH_BACK, 32'h8000_0000);
      send_operation(MODE_PUSH_FRONT, 32'h0000_0000);
      send_operation(MODE_PUSH_BACK, 32'hffff_ffff);
      send_operation(MODE_QUERY, $urandom);
      send_operation(MODE_QUERY + 3'd1, $urandom);
      send_operation(MODE_QUERY + 3'd2, $urandom);
      send_operation(MODE_QUERY + 3'd3, $urandom);
      send_operation(MODE_POP_FRONT, $urandom);
      send_operation(MODE_POP_BACK, $urandom);
      send_operation(MODE_POP_FRONT, $urandom);
      send_operation(MODE_POP_BACK, $urandom);
      send_operation(MODE_POP_BACK, $urandom);
      send_operation(MODE_PUSH_BACK, 32'h5555_5555);
      send_operation(MODE_PUSH_FRONT, 32'haaaa_aaaa);
      send_operation(MODE_POP_FRONT, $urandom);
      send_operation(MODE_POP_FRONT, $urandom);
      send_operation(MODE_POP_FRONT, $urandom);

      // segments that fill past full, drain past empty, or churn in between
      sent = 0;
      while (sent < RANDOM_OPS) begin
         bias = $urandom_range(BIAS_FILL, BIAS_MIX);
         seg_len = $urandom_range(60, 160);
         if (seg_len > RANDOM_OPS - sent)
            seg_len = RANDOM_OPS - sent;
         steady = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            send_operation(pick_mode(bias), pick_word());
            sent++;
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
+incdir+sv
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/dq_dpath.sv
sv/double_ended_queue.sv
dv/double_ended_queue_checker.sv
dv/double_ended_queue_tb.sv
